[design/iracfe_pkg.sv]
package iracfe_pkg;

  localparam int unsigned FrameBits = 64;
  localparam int unsigned DurW      = 16;
  localparam int unsigned CntW      = $clog2(FrameBits);

  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 40;

  localparam logic [DurW-1:0] OneDurReset  = 16'd1630;
  localparam logic [DurW-1:0] ZeroDurReset = 16'd560;

  typedef enum logic {
    REG_ONE_DUR  = 1'b0,
    REG_ZERO_DUR = 1'b1
  } cfg_reg_e;

  typedef logic [FrameBits-1:0] frame_t;

  function automatic logic [3:0] rev4(input logic [3:0] v);
    rev4 = {v[0], v[1], v[2], v[3]};
  endfunction

  // Packs one command and appends the checksum. The checksum is the sum of the
  // fourteen upper nibbles, each reversed, and the 8-bit sum is reversed again.
  function automatic frame_t build_frame(input logic [3:0] power,
                                         input logic [1:0] mode,
                                         input logic [2:0] fan,
                                         input logic [5:0] temp);
    frame_t     f;
    logic [7:0] sum;
    f          = '0;
    sum        = '0;
    f[63]      = 1'b1;
    f[55:54]   = mode;
    f[53:51]   = fan;
    f[46:41]   = {temp[0], temp[1], temp[2], temp[3], temp[4], temp[5]};
    f[19:16]   = power;
    for (int n = 2; n < 16; n++) begin
      sum = sum + {4'd0, rev4(f[n*4 +: 4])};
    end
    f[7:0] = {sum[0], sum[1], sum[2], sum[3], sum[4], sum[5], sum[6], sum[7]};
    build_frame = f;
  endfunction

endpackage

[design/ir_ac_frame_encoder_top.sv]
// Channel | Direction | Transfer contents
// s_axis  | in        | tdata: power_code[3:0], mode_code[5:4], fan_code[8:6],
//         |           |        temperature[14:9], zero fill
// m_axis  | out       | tdata: bit_value[0], first_half[16:1], second_half[32:17],
//         |           |        zero fill; tlast: last_bit
// cfg     | in        | register write, no read-back
//
// Each command produces 64 output transfers, one per cycle while m_axis_tready is
// high; the frame shift register sets this figure. One command waits in the input
// register while the previous frame shifts out. Reset clears all valid flags and
// loads the default durations.
// A stall on m_axis holds the output register and the shift register.
module ir_ac_frame_encoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // power_code[3:0], mode_code[5:4], fan_code[8:6], temperature[14:9]
  input  logic [iracfe_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bit_value[0], first_half[16:1], second_half[32:17]
  output logic [iracfe_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [iracfe_pkg::DurW-1:0]       cfg_data_i
);
  import iracfe_pkg::*;

  logic [DurW-1:0] one_dur_q, zero_dur_q;

  logic       in_valid_q;
  logic [3:0] power_q;
  logic [1:0] mode_q;
  logic [2:0] fan_q;
  logic [5:0] temp_q;

  logic            busy_q;
  frame_t          frame_q;
  logic [CntW-1:0] cnt_q;

  logic out_valid_q, out_bit_q, out_last_q;

  logic out_adv, shift_last, shift_free, load, in_take;

  assign out_adv    = !out_valid_q || m_axis_tready;
  assign shift_last = (cnt_q == CntW'(FrameBits - 1));
  assign shift_free = !busy_q || (out_adv && shift_last);
  assign load       = shift_free && in_valid_q;
  assign in_take    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_dur_q  <= OneDurReset;
      zero_dur_q <= ZeroDurReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ONE_DUR:  one_dur_q  <= cfg_data_i;
        REG_ZERO_DUR: zero_dur_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      power_q <= s_axis_tdata[3:0];
      mode_q  <= s_axis_tdata[5:4];
      fan_q   <= s_axis_tdata[8:6];
      temp_q  <= s_axis_tdata[14:9];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && out_adv) begin
      busy_q <= !shift_last;
      cnt_q  <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= build_frame(power_q, mode_q, fan_q, temp_q);
    end else if (busy_q && out_adv) begin
      frame_q <= {frame_q[FrameBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && busy_q) begin
      out_bit_q  <= frame_q[FrameBits-1];
      out_last_q <= shift_last;
    end
  end

  // The user must rewrite durations only while idle (not enforced), so selecting
  // them after the output register keeps the payload stable during a stall.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0,
                          out_bit_q ? zero_dur_q : one_dur_q,
                          out_bit_q ? one_dur_q : zero_dur_q,
                          out_bit_q};

endmodule
